FILE: rtl/sxp_pkg.sv
// Shared types and constants of the SysEx message parser.
// Item structs for the frame, result and internal queue sides.
// No dependencies.
`default_nettype none

package sxp_pkg;

  // Frame markers and body layout.
  localparam logic [7:0] FRAME_BEGIN    = 8'hF0;
  localparam logic [7:0] FRAME_END_BYTE = 8'hF7;
  localparam logic [3:0] POS_CMD        = 4'd3;
  localparam logic [3:0] POS_PAYLOAD    = 4'd4;
  localparam logic [3:0] POS_MAX        = 4'd15;
  localparam int         PAYLOAD_DEPTH  = 5;
  localparam logic [3:0] NAME_START     = 4'd3;
  localparam logic [3:0] LEN_FULL       = 4'd5;
  localparam logic [3:0] LEN_TRACK      = 4'd3;
  localparam logic [6:0] MASK7          = 7'h7F;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TAG_FIRST   = 3'd0,
    REG_TAG_SECOND  = 3'd1,
    REG_TAG_THIRD   = 3'd2,
    REG_CODE_SEED   = 3'd3,
    REG_CODE_DUMP   = 3'd4,
    REG_CODE_GLOBAL = 3'd5,
    REG_CODE_TRACK  = 3'd6
  } cfg_reg_t;

  // Configuration reset values.
  localparam logic [7:0] RST_TAG         = 8'd0;
  localparam logic [7:0] RST_CODE_SEED   = 8'd0;
  localparam logic [7:0] RST_CODE_DUMP   = 8'd1;
  localparam logic [7:0] RST_CODE_GLOBAL = 8'd2;
  localparam logic [7:0] RST_CODE_TRACK  = 8'd3;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_SEED    = 3'd1,
    KIND_DUMP    = 3'd2,
    KIND_GLOBALS = 3'd3,
    KIND_TRACK   = 3'd4,
    KIND_NAME    = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] tag_byte_first;
    logic [7:0] tag_byte_second;
    logic [7:0] tag_byte_third;
    logic [7:0] code_seed;
    logic [7:0] code_dump_begin;
    logic [7:0] code_globals;
    logic [7:0] code_track_engine;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] seed_value;
    logic [7:0]  patch_mode;
    logic [13:0] tempo_bpm;
    logic [7:0]  tonic_value;
    logic [7:0]  scale_number;
    logic [7:0]  track_number;
    logic [7:0]  extra_byte_a;
    logic [7:0]  extra_byte_b;
    logic [7:0]  name_byte;
    logic        last_result;
  } result_item_t;

  // What the front hands to the back for one frame byte.
  typedef struct packed {
    logic                                 name_valid;
    logic [7:0]                           name_byte;
    logic                                 final_valid;
    kind_t                                kind;
    logic [PAYLOAD_DEPTH-1:0][7:0]        payload;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/sxp_fifo.sv
// Small first-in first-out queue of registers with show-ahead read.
// Generic in width and depth; no package dependency.
`default_nettype none

module sxp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sxp_front.sv
// Front end: tracks the frame position, checks the tag, stores the payload
// and classifies each byte into a queue entry. Depends on sxp_pkg.
`default_nettype none

module sxp_front
  import sxp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        item_valid,
  input  wire frame_item_t item,
  output logic             entry_push,
  output entry_t           entry
);

  logic       at_start;
  logic [3:0] body_pos;
  logic       tag_ok;
  logic [7:0] cmd;
  logic [7:0] store [PAYLOAD_DEPTH];
  logic       name_done;

  logic       is_body;
  logic       in_payload;
  logic [3:0] pay_idx;
  logic [7:0] want;
  logic       tag_ok_next;
  logic [7:0] cmd_next;
  logic [3:0] body_pos_next;
  logic       name_hit;
  logic       emit_name;
  logic [3:0] plen;
  logic [PAYLOAD_DEPTH-1:0][7:0] pay;
  kind_t      kind;

  // Expected tag byte for the current body position.
  always_comb begin
    unique case (body_pos)
      4'd0:    want = cfg.tag_byte_first;
      4'd1:    want = cfg.tag_byte_second;
      default: want = cfg.tag_byte_third;
    endcase
  end

  // Per-byte update of the frame state.
  always_comb begin
    is_body = !((at_start && item.frame_byte == FRAME_BEGIN) ||
                (item.frame_end && item.frame_byte == FRAME_END_BYTE));
    in_payload = (body_pos >= POS_PAYLOAD);
    pay_idx    = body_pos - POS_PAYLOAD;
    tag_ok_next = tag_ok &&
                  !(is_body && body_pos < POS_CMD && item.frame_byte != want);
    cmd_next = (is_body && body_pos == POS_CMD) ? item.frame_byte : cmd;
    body_pos_next = (is_body && body_pos != POS_MAX) ? body_pos + 4'd1 : body_pos;
    name_hit  = is_body && in_payload && pay_idx >= NAME_START && tag_ok &&
                cmd == cfg.code_track_engine && !name_done;
    emit_name = name_hit && item.frame_byte != 8'd0;
  end

  // Payload as it stands after this byte, with the current byte forwarded.
  always_comb begin
    for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
      pay[i] = (is_body && in_payload && pay_idx == 4'(i)) ? item.frame_byte
                                                            : store[i];
    end
  end

  // Message classification at frame end; code order decides on equal codes.
  always_comb begin
    plen = body_pos_next - POS_PAYLOAD;
    kind = KIND_NONE;
    if (tag_ok_next && body_pos_next >= POS_PAYLOAD) begin
      priority if (cmd_next == cfg.code_seed) begin
        if (plen >= LEN_FULL) kind = KIND_SEED;
      end else if (cmd_next == cfg.code_dump_begin) begin
        if (plen == 4'd0) kind = KIND_DUMP;
      end else if (cmd_next == cfg.code_globals) begin
        if (plen >= LEN_FULL) kind = KIND_GLOBALS;
      end else if (cmd_next == cfg.code_track_engine) begin
        if (plen >= LEN_TRACK) kind = KIND_TRACK;
      end else begin
        kind = KIND_NONE;
      end
    end
  end

  // Queue entry for this byte.
  always_comb begin
    entry.name_valid  = emit_name;
    entry.name_byte   = item.frame_byte;
    entry.final_valid = item.frame_end;
    entry.kind        = kind;
    entry.payload     = pay;
    entry_push        = item_valid && (emit_name || item.frame_end);
  end

  // Frame state registers; cleared at each frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      at_start  <= 1'b1;
      body_pos  <= '0;
      tag_ok    <= 1'b1;
      cmd       <= '0;
      name_done <= 1'b0;
    end else if (item_valid) begin
      if (item.frame_end) begin
        at_start  <= 1'b1;
        body_pos  <= '0;
        tag_ok    <= 1'b1;
        cmd       <= '0;
        name_done <= 1'b0;
      end else begin
        at_start  <= 1'b0;
        body_pos  <= body_pos_next;
        tag_ok    <= tag_ok_next;
        cmd       <= cmd_next;
        name_done <= name_done || (name_hit && item.frame_byte == 8'd0);
      end
    end
  end

  // Payload store keeps its contents across frames.
  always_ff @(posedge clk) begin
    if (item_valid && is_body && in_payload && pay_idx < 4'(PAYLOAD_DEPTH)) begin
      store[pay_idx[2:0]] <= item.frame_byte;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sxp_back.sv
// Back end: expands each queue entry into one or two result items and
// formats the message fields into the output register. Depends on sxp_pkg.
`default_nettype none

module sxp_back
  import sxp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire entry_t head,
  input  wire logic   head_valid,
  output logic        head_pop,
  output logic        empty,
  input  wire logic   pop,
  output result_item_t result_item
);

  logic         res_valid;
  result_item_t res;
  logic         name_phase;

  logic         load;
  logic         take_name;
  result_item_t res_next;

  assign empty       = !res_valid;
  assign result_item = res;

  // Choose the next result from the head entry.
  always_comb begin
    load      = !res_valid || pop;
    take_name = head.name_valid && !name_phase;
    head_pop  = load && head_valid && !(take_name && head.final_valid);
    res_next  = '0;
    if (take_name) begin
      res_next.kind        = KIND_NAME;
      res_next.name_byte   = head.name_byte;
      res_next.last_result = !head.final_valid;
    end else begin
      res_next.kind        = head.kind;
      res_next.last_result = 1'b1;
      unique case (head.kind)
        KIND_SEED: begin
          res_next.seed_value = {head.payload[4][3:0], head.payload[3][6:0],
                                 head.payload[2][6:0], head.payload[1][6:0],
                                 head.payload[0][6:0]};
        end
        KIND_GLOBALS: begin
          res_next.patch_mode   = head.payload[0];
          res_next.tempo_bpm    = {head.payload[2][6:0] & MASK7,
                                   head.payload[1][6:0] & MASK7};
          res_next.tonic_value  = head.payload[3];
          res_next.scale_number = head.payload[4];
        end
        KIND_TRACK: begin
          res_next.track_number = head.payload[0];
          res_next.extra_byte_a = head.payload[1];
          res_next.extra_byte_b = head.payload[2];
        end
        default: begin
        end
      endcase
    end
  end

  // Output register and name phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      name_phase <= 1'b0;
    end else if (load) begin
      res_valid <= head_valid;
      if (head_valid) begin
        name_phase <= take_name && head.final_valid;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sysex_message_parser_unit.sv
// SysEx message parser: one frame byte per item, results through a queue port.
// A result passes through the internal queue and then the result register.
// Throughput: one item per cycle while the queue is not full; a frame-end byte
// that also sends a name byte gives two results in turn from the single result register.
// Reset clears frame state, queues and registers to defaults; the payload
// store is not cleared. Depends on sxp_pkg, sxp_front, sxp_fifo, sxp_back.
`default_nettype none

module sysex_message_parser_unit
  import sxp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire frame_item_t  frame_item,
  output logic              empty,
  input  wire logic         pop,
  output result_item_t      result_item,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [7:0]   cfg_data
);

  cfg_t   cfg;
  logic   accept;
  logic   entry_push;
  entry_t entry;
  entry_t head;
  logic   q_full;
  logic   q_empty;
  logic   head_pop;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tag_byte_first    <= RST_TAG;
      cfg.tag_byte_second   <= RST_TAG;
      cfg.tag_byte_third    <= RST_TAG;
      cfg.code_seed         <= RST_CODE_SEED;
      cfg.code_dump_begin   <= RST_CODE_DUMP;
      cfg.code_globals      <= RST_CODE_GLOBAL;
      cfg.code_track_engine <= RST_CODE_TRACK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TAG_FIRST:   cfg.tag_byte_first    <= cfg_data;
        REG_TAG_SECOND:  cfg.tag_byte_second   <= cfg_data;
        REG_TAG_THIRD:   cfg.tag_byte_third    <= cfg_data;
        REG_CODE_SEED:   cfg.code_seed         <= cfg_data;
        REG_CODE_DUMP:   cfg.code_dump_begin   <= cfg_data;
        REG_CODE_GLOBAL: cfg.code_globals      <= cfg_data;
        REG_CODE_TRACK:  cfg.code_track_engine <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end: classification.
  sxp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (accept),
    .item       (frame_item),
    .entry_push (entry_push),
    .entry      (entry)
  );

  // Queue between front and back.
  sxp_fifo #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (entry_push),
    .wr_data (entry),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back end: result formatting.
  sxp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (!q_empty),
    .head_pop    (head_pop),
    .empty       (empty),
    .pop         (pop),
    .result_item (result_item)
  );

  // A name result never carries a zero character.
  a_name_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_item.kind == KIND_NAME) |-> (result_item.name_byte != 8'd0))
    else $error("name result with zero character");

  // Every message result closes the results of its byte.
  a_msg_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_item.kind != KIND_NAME) |-> result_item.last_result)
    else $error("message result not marked last");

  // The internal queue is never both full and empty.
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  // A pop from an empty queue never happens.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> !q_empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the SysEx message parser unit.
// Feeds frames of bytes, predicts each frame's results and compares them on pop.
// Depends on sxp_pkg and sysex_message_parser_unit.

module tb_top
  import sxp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Frame layout as the parser sees it.
  localparam logic [7:0] MARK_START    = 8'hF0;
  localparam logic [7:0] MARK_END      = 8'hF7;
  localparam logic [3:0] TAG_BYTES     = 4'd3;
  localparam logic [3:0] BODY_SAT      = 4'd15;
  localparam logic [3:0] FULL_PAYLOAD  = 4'd5;
  localparam logic [3:0] TRACK_PAYLOAD = 4'd3;
  localparam logic [3:0] PAYLOAD_SLOTS = 4'd5;

  localparam int IDLE_PCT      = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  typedef logic [7:0] byte_q_t[$];

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         push = 1'b0;
  logic         full;
  frame_item_t  frame_item = '0;
  logic         empty;
  logic         pop = 1'b0;
  result_item_t result_item;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [7:0]   cfg_data = '0;

  // Parser settings and per-frame state as the testbench tracks them.
  cfg_t parser_cfg = '{tag_byte_first: 8'h00, tag_byte_second: 8'h00,
                       tag_byte_third: 8'h00, code_seed: 8'h00,
                       code_dump_begin: 8'h01, code_globals: 8'h02,
                       code_track_engine: 8'h03};
  logic       at_frame_head = 1'b1;
  logic [3:0] body_count = '0;
  logic       tag_ok = 1'b1;
  logic [7:0] command_byte = '0;
  logic [7:0] payload_bytes [5];
  logic       name_stopped = 1'b0;

  result_item_t expected_results[$];
  int send_idle_pct = IDLE_PCT;
  int pop_stall_pct = IDLE_PCT;
  int bytes_accepted = 0;
  int results_seen = 0;
  int failures = 0;

  sysex_message_parser_unit u_dut (
    .clk,
    .rst,
    .push,
    .full,
    .frame_item,
    .empty,
    .pop,
    .result_item,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Appends one byte at the tail of a byte queue.
  function automatic void add_byte(ref byte_q_t q, input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  // Appends one result at the tail of the expected results.
  function automatic void add_expected(input result_item_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // The tag byte expected at a given body position.
  function automatic logic [7:0] expected_tag(logic [3:0] pos);
    case (pos)
      4'd0: return parser_cfg.tag_byte_first;
      4'd1: return parser_cfg.tag_byte_second;
      default: return parser_cfg.tag_byte_third;
    endcase
  endfunction

  // Decoded message for the frame that just ended.
  function automatic result_item_t frame_message();
    result_item_t m;
    logic [3:0] plen;
    m = '0;
    m.kind = KIND_NONE;
    m.last_result = 1'b1;
    if (tag_ok && body_count > TAG_BYTES) begin
      plen = body_count - TAG_BYTES - 4'd1;
      if (command_byte == parser_cfg.code_seed) begin
        if (plen >= FULL_PAYLOAD) begin
          m.kind = KIND_SEED;
          m.seed_value = {payload_bytes[4][3:0], payload_bytes[3][6:0],
                          payload_bytes[2][6:0], payload_bytes[1][6:0],
                          payload_bytes[0][6:0]};
        end
      end else if (command_byte == parser_cfg.code_dump_begin) begin
        if (plen == 4'd0) m.kind = KIND_DUMP;
      end else if (command_byte == parser_cfg.code_globals) begin
        if (plen >= FULL_PAYLOAD) begin
          m.kind = KIND_GLOBALS;
          m.patch_mode = payload_bytes[0];
          m.tempo_bpm = {payload_bytes[2][6:0], payload_bytes[1][6:0]};
          m.tonic_value = payload_bytes[3];
          m.scale_number = payload_bytes[4];
        end
      end else if (command_byte == parser_cfg.code_track_engine) begin
        if (plen >= TRACK_PAYLOAD) begin
          m.kind = KIND_TRACK;
          m.track_number = payload_bytes[0];
          m.extra_byte_a = payload_bytes[1];
          m.extra_byte_b = payload_bytes[2];
        end
      end
    end
    return m;
  endfunction

  // Advance the parser state by one accepted frame byte and queue its results.
  function automatic void parse_frame_byte(frame_item_t it);
    result_item_t name_res;
    logic [3:0] slot;
    logic head;
    logic has_name;
    head = at_frame_head;
    at_frame_head = 1'b0;
    has_name = 1'b0;
    name_res = '0;
    if (!(head && it.frame_byte == MARK_START) &&
        !(it.frame_end && it.frame_byte == MARK_END)) begin
      if (body_count < TAG_BYTES) begin
        if (it.frame_byte != expected_tag(body_count)) tag_ok = 1'b0;
      end else if (body_count == TAG_BYTES) begin
        command_byte = it.frame_byte;
      end else begin
        slot = body_count - TAG_BYTES - 4'd1;
        if (slot < PAYLOAD_SLOTS) payload_bytes[slot] = it.frame_byte;
        // Engine name characters start at the fourth payload byte.
        if (slot >= TRACK_PAYLOAD && tag_ok && !name_stopped &&
            command_byte == parser_cfg.code_track_engine) begin
          if (it.frame_byte == 8'h00) begin
            name_stopped = 1'b1;
          end else begin
            has_name = 1'b1;
            name_res.kind = KIND_NAME;
            name_res.name_byte = it.frame_byte;
            name_res.last_result = !it.frame_end;
          end
        end
      end
      if (body_count != BODY_SAT) body_count = body_count + 4'd1;
    end
    if (has_name) add_expected(name_res);
    if (it.frame_end) begin
      add_expected(frame_message());
      at_frame_head = 1'b1;
      body_count = '0;
      tag_ok = 1'b1;
      command_byte = '0;
      name_stopped = 1'b0;
    end
  endfunction

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endfunction

  // Lists every field that differs between the expected and received result.
  function automatic string field_diffs(result_item_t want, result_item_t got);
    string s;
    s = "";
    if (got.kind !== want.kind)
      s = {s, $sformatf(" kind exp %0d got %0d", want.kind, got.kind)};
    if (got.seed_value !== want.seed_value)
      s = {s, $sformatf(" seed_value exp %h got %h", want.seed_value, got.seed_value)};
    if (got.patch_mode !== want.patch_mode)
      s = {s, $sformatf(" patch_mode exp %h got %h", want.patch_mode, got.patch_mode)};
    if (got.tempo_bpm !== want.tempo_bpm)
      s = {s, $sformatf(" tempo_bpm exp %h got %h", want.tempo_bpm, got.tempo_bpm)};
    if (got.tonic_value !== want.tonic_value)
      s = {s, $sformatf(" tonic_value exp %h got %h", want.tonic_value, got.tonic_value)};
    if (got.scale_number !== want.scale_number)
      s = {s, $sformatf(" scale_number exp %h got %h", want.scale_number, got.scale_number)};
    if (got.track_number !== want.track_number)
      s = {s, $sformatf(" track_number exp %h got %h", want.track_number, got.track_number)};
    if (got.extra_byte_a !== want.extra_byte_a)
      s = {s, $sformatf(" extra_byte_a exp %h got %h", want.extra_byte_a, got.extra_byte_a)};
    if (got.extra_byte_b !== want.extra_byte_b)
      s = {s, $sformatf(" extra_byte_b exp %h got %h", want.extra_byte_b, got.extra_byte_b)};
    if (got.name_byte !== want.name_byte)
      s = {s, $sformatf(" name_byte exp %h got %h", want.name_byte, got.name_byte)};
    if (got.last_result !== want.last_result)
      s = {s, $sformatf(" last_result exp %b got %b", want.last_result, got.last_result)};
    return s;
  endfunction

  function automatic void check_result(result_item_t got);
    result_item_t want;
    string diffs;
    results_seen++;
    if (expected_results.size() == 0) begin
      note_failure($sformatf("result %0d arrived with none expected, kind %0d",
                             results_seen, got.kind));
      return;
    end
    want = expected_results.pop_front();
    diffs = field_diffs(want, got);
    if (diffs != "") note_failure($sformatf("result %0d:%s", results_seen, diffs));
  endfunction

  // Result side: take an item whenever pop and not empty, stall pop at random.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(result_item);
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Sends one frame byte, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] value, input logic last);
    frame_item_t it;
    it.frame_byte = value;
    it.frame_end = last;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    frame_item <= it;
    do @(posedge clk); while (full);
    bytes_accepted++;
    parse_frame_byte(it);
  endtask

  // Sends a body with optional start and end markers; frame_end on the last byte.
  task automatic send_frame(input byte_q_t body, input bit lead, input bit trail);
    byte_q_t seq;
    seq = body;
    if (lead) seq.push_front(MARK_START);
    if (trail) add_byte(seq, MARK_END);
    if (seq.size() == 0) add_byte(seq, 8'($urandom));
    for (int i = 0; i < seq.size(); i++) send_byte(seq[i], i == seq.size() - 1);
  endtask

  // Holds the sender until every expected result is in and the pipeline is quiet.
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; valid stays high for the next write.
  task automatic put_reg(input cfg_reg_t idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TAG_FIRST:   parser_cfg.tag_byte_first = value;
      REG_TAG_SECOND:  parser_cfg.tag_byte_second = value;
      REG_TAG_THIRD:   parser_cfg.tag_byte_third = value;
      REG_CODE_SEED:   parser_cfg.code_seed = value;
      REG_CODE_DUMP:   parser_cfg.code_dump_begin = value;
      REG_CODE_GLOBAL: parser_cfg.code_globals = value;
      REG_CODE_TRACK:  parser_cfg.code_track_engine = value;
      default: ;
    endcase
  endtask

  // Writes all seven registers while the parser is idle.
  task automatic apply_settings(input cfg_t s);
    wait_drained();
    put_reg(REG_TAG_FIRST, s.tag_byte_first);
    put_reg(REG_TAG_SECOND, s.tag_byte_second);
    put_reg(REG_TAG_THIRD, s.tag_byte_third);
    put_reg(REG_CODE_SEED, s.code_seed);
    put_reg(REG_CODE_DUMP, s.code_dump_begin);
    put_reg(REG_CODE_GLOBAL, s.code_globals);
    put_reg(REG_CODE_TRACK, s.code_track_engine);
    cfg_valid <= 1'b0;
  endtask

  // A frame aimed at one of the commands, with occasional damage.
  task automatic send_message_frame();
    byte_q_t body;
    int plen;
    int names;
    int keep;
    logic [7:0] cmd;
    logic is_track;
    body = {parser_cfg.tag_byte_first, parser_cfg.tag_byte_second,
            parser_cfg.tag_byte_third};
    is_track = 1'b0;
    if ($urandom_range(9) == 0) begin
      keep = $urandom_range(2);
      body[keep] = body[keep] ^ (8'h01 << $urandom_range(7));
    end
    plen = ($urandom_range(4) == 0) ? int'($urandom_range(0, 13)) : -1;
    case ($urandom_range(9))
      0, 1: begin
        cmd = parser_cfg.code_seed;
        if (plen < 0) plen = FULL_PAYLOAD;
      end
      2, 3: begin
        cmd = parser_cfg.code_dump_begin;
        if (plen < 0) plen = 0;
      end
      4, 5: begin
        cmd = parser_cfg.code_globals;
        if (plen < 0) plen = FULL_PAYLOAD;
      end
      6, 7, 8: begin
        cmd = parser_cfg.code_track_engine;
        is_track = 1'b1;
        if (plen < 0) plen = TRACK_PAYLOAD;
      end
      default: begin
        cmd = 8'($urandom);
        if (plen < 0) plen = $urandom_range(0, 5);
      end
    endcase
    add_byte(body, cmd);
    repeat (plen) add_byte(body, 8'($urandom));
    // Engine name, optionally cut by a zero and followed by ignored bytes.
    if (is_track) begin
      names = $urandom_range(0, 6);
      repeat (names) add_byte(body, 8'($urandom_range(1, 255)));
      if ($urandom_range(1)) begin
        add_byte(body, 8'h00);
        repeat ($urandom_range(0, 3)) add_byte(body, 8'($urandom));
      end
    end
    // Now and then cut the body short of a command.
    if ($urandom_range(19) == 0) begin
      keep = $urandom_range(0, 3);
      while (body.size() > keep) void'(body.pop_back());
    end
    send_frame(body, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // A frame of loose bytes, biased toward markers and zero.
  task automatic send_noise_frame();
    byte_q_t body;
    int n;
    n = $urandom_range(1, 18);
    repeat (n) begin
      case ($urandom_range(7))
        0: add_byte(body, MARK_START);
        1: add_byte(body, MARK_END);
        2: add_byte(body, 8'h00);
        default: add_byte(body, 8'($urandom));
      endcase
    end
    send_frame(body, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic stream_frames(input int n_items);
    int start;
    start = bytes_accepted;
    while (bytes_accepted - start < n_items) begin
      if ($urandom_range(4) == 0) send_noise_frame();
      else send_message_frame();
    end
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.tag_byte_first = ($urandom_range(3) == 0) ? MARK_START : 8'($urandom);
    s.tag_byte_second = 8'($urandom);
    s.tag_byte_third = ($urandom_range(3) == 0) ? MARK_END : 8'($urandom);
    s.code_seed = 8'($urandom_range(7));
    s.code_dump_begin = 8'($urandom_range(7));
    s.code_globals = 8'($urandom_range(7));
    s.code_track_engine = 8'($urandom_range(7));
    return s;
  endfunction

  // Each command once at reset settings, plus lone marker frames.
  task automatic test_directed_defaults();
    byte_q_t tags;
    byte_q_t body;
    tags = {parser_cfg.tag_byte_first, parser_cfg.tag_byte_second,
            parser_cfg.tag_byte_third};
    body = {tags, parser_cfg.code_dump_begin};
    send_frame(body, 1'b1, 1'b1);
    body = {tags, parser_cfg.code_seed, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(body, 1'b0, 1'b0);
    body = {tags, parser_cfg.code_globals, 8'hFF, MARK_END, MARK_START, 8'h80, 8'hFF};
    send_frame(body, 1'b0, 1'b0);
    // Name characters, the last one on the frame-end byte itself.
    body = {tags, parser_cfg.code_track_engine, 8'h7F, 8'h80, 8'hFF, 8'h41, 8'h5A};
    send_frame(body, 1'b0, 1'b0);
    body = {};
    send_frame(body, 1'b1, 1'b0);
    send_frame(body, 1'b0, 1'b1);
  endtask

  // Random traffic at reset settings, with one full drain halfway.
  task automatic test_default_traffic();
    stream_frames(175);
    wait_drained();
    stream_frames(175);
  endtask

  // Neither side idles for a long stretch.
  task automatic test_back_to_back();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    stream_frames(250);
    wait_drained();
    send_idle_pct = IDLE_PCT;
    pop_stall_pct = IDLE_PCT;
  endtask

  task automatic test_extreme_settings();
    cfg_t s;
    s = '{tag_byte_first: 8'hFF, tag_byte_second: 8'hFF, tag_byte_third: 8'hFF,
          code_seed: 8'hFF, code_dump_begin: 8'h00, code_globals: 8'h80,
          code_track_engine: 8'h7F};
    apply_settings(s);
    stream_frames(200);
    // Marker values as tags and codes.
    s = '{tag_byte_first: 8'h00, tag_byte_second: MARK_START, tag_byte_third: MARK_END,
          code_seed: MARK_START, code_dump_begin: MARK_END, code_globals: 8'h01,
          code_track_engine: 8'hFF};
    apply_settings(s);
    stream_frames(200);
  endtask

  // Codes that collide resolve as seed, dump begin, globals, track engine.
  task automatic test_shared_codes();
    cfg_t s;
    s = random_settings();
    s.code_globals = s.code_seed;
    s.code_track_engine = s.code_dump_begin;
    apply_settings(s);
    stream_frames(100);
    s = random_settings();
    s.code_dump_begin = s.code_seed;
    s.code_globals = s.code_seed;
    s.code_track_engine = s.code_seed;
    apply_settings(s);
    stream_frames(100);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      apply_settings(random_settings());
      stream_frames(130);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_defaults();
    test_default_traffic();
    test_back_to_back();
    test_extreme_settings();
    test_shared_codes();
    test_random_settings();
    wait_drained();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ERROR: cycle limit reached, %0d results still expected",
             expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
